// File: src/topic_filter_match_table_assert.svh
// Assertion macros for the topic filter match table.
`ifndef TOPIC_FILTER_MATCH_TABLE_ASSERT_SVH
`define TOPIC_FILTER_MATCH_TABLE_ASSERT_SVH

// same-cycle implication
`define TFM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TFM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/tfm_pkg.sv
// Shared constants and types of the topic filter match table.
`default_nettype none
package tfm_pkg;
	localparam int ENTRIES_DEF      = 12;
	localparam int FILTER_CHARS_DEF = 64;
	localparam int TOPIC_CHARS_DEF  = 128;

	localparam int MASK_W     = 12;
	localparam int SLOT_OUT_W = 4;
	localparam int KIND_W     = 2;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	localparam logic [KIND_W-1:0] KIND_MATCH  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STORED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FULL   = 2'd2;

	localparam logic REQ_FILTER = 1'b0;
	localparam logic REQ_TOPIC  = 1'b1;

	typedef struct packed {
		logic load_byte;
		logic topic_byte;
		logic step;
		logic finish;
		logic commit;
	} tfm_cmd_t;

	typedef struct packed {
		logic topic_sat;
		logic cont;
		logic act_any;
	} tfm_stat_t;
endpackage
`default_nettype wire

// File: src/tfm_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module tfm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// File: src/tfm_datapath.sv
// Datapath: filter memories, per-entry matchers, load state, result register.
`default_nettype none
module tfm_datapath import tfm_pkg::*; #(
	parameter int ENTRIES      = ENTRIES_DEF,
	parameter int FILTER_CHARS = FILTER_CHARS_DEF,
	parameter int TOPIC_CHARS  = TOPIC_CHARS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tfm_cmd_t              cmd,
	input  wire logic [7:0]            data_byte,
	output tfm_stat_t                  stat,
	output logic      [KIND_W-1:0]     res_kind,
	output logic      [MASK_W-1:0]     res_mask,
	output logic      [SLOT_OUT_W-1:0] res_slot
);
	localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int FW = $clog2(FILTER_CHARS);
	localparam int TW = $clog2(TOPIC_CHARS);

	logic [ENTRIES-1:0] used_q, skip_q, fail_q, match_q, act_q;
	logic [FW-1:0]      len_q [ENTRIES];
	logic [FW-1:0]      pos_q [ENTRIES];
	logic [TW-1:0]      tcnt_q;
	logic [7:0]         ch_q;
	logic               ld_busy_q, ld_rej_q;
	logic [SW-1:0]      ld_slot_q;
	logic [FW-1:0]      ld_cnt_q;
	logic [KIND_W-1:0]     kind_q;
	logic [MASK_W-1:0]     mask_q;
	logic [SLOT_OUT_W-1:0] slot_q;

	logic [7:0]         rd [ENTRIES];
	logic [ENTRIES-1:0] nx_skip, nx_fail, nx_match, nx_act, fin;
	logic [FW-1:0]      nx_pos [ENTRIES];
	logic [MASK_W-1:0]  fin_mask;

	logic          free_hit;
	logic [SW-1:0] free_idx;
	logic          ld_start, ld_busy_n, ld_rej_n, wr_en;
	logic [SW-1:0] ld_slot_n;
	logic [FW-1:0] ld_cnt_cur;

	// first free entry
	always_comb begin
		free_hit = 1'b0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_hit = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	always_comb begin
		ld_start   = !ld_busy_q && !ld_rej_q;
		ld_busy_n  = ld_start ? free_hit : ld_busy_q;
		ld_rej_n   = ld_start ? !free_hit : ld_rej_q;
		ld_slot_n  = ld_start ? free_idx : ld_slot_q;
		ld_cnt_cur = ld_start ? '0 : ld_cnt_q;
		wr_en      = cmd.load_byte && ld_busy_n &&
			(ld_cnt_cur < FW'(FILTER_CHARS - 1));
	end

	for (genvar e = 0; e < ENTRIES; e++) begin : g_entry
		tfm_ram #(.WIDTH(8), .DEPTH(FILTER_CHARS)) u_ram (
			.clk  (clk),
			.we   (wr_en && (ld_slot_n == SW'(e))),
			.waddr(ld_cnt_cur),
			.wdata(data_byte),
			.raddr(pos_q[e]),
			.rdata(rd[e])
		);

		always_comb begin
			nx_pos[e]   = pos_q[e];
			nx_skip[e]  = skip_q[e];
			nx_fail[e]  = fail_q[e];
			nx_match[e] = match_q[e];
			nx_act[e]   = 1'b0;
			if (act_q[e] && !fail_q[e] && !match_q[e] &&
				!(skip_q[e] && ch_q != CH_SLASH)) begin
				nx_skip[e] = 1'b0;
				if (pos_q[e] >= len_q[e]) begin
					nx_fail[e] = 1'b1;
				end else if (rd[e] == CH_HASH) begin
					nx_match[e] = 1'b1;
				end else if (rd[e] == CH_PLUS) begin
					nx_pos[e] = pos_q[e] + FW'(1);
					if (ch_q != CH_SLASH) begin
						nx_skip[e] = 1'b1;
					end else begin
						nx_act[e] = 1'b1;
					end
				end else if (rd[e] == ch_q) begin
					nx_pos[e] = pos_q[e] + FW'(1);
				end else begin
					nx_fail[e] = 1'b1;
				end
			end
		end

		assign fin[e] = used_q[e] && !fail_q[e] && (match_q[e] ||
			(pos_q[e] < len_q[e] && rd[e] == CH_HASH) || pos_q[e] == len_q[e]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				used_q[e]  <= 1'b0;
				pos_q[e]   <= '0;
				skip_q[e]  <= 1'b0;
				fail_q[e]  <= 1'b0;
				match_q[e] <= 1'b0;
				act_q[e]   <= 1'b0;
			end else if (cmd.topic_byte) begin
				act_q[e] <= 1'b1;
			end else if (cmd.step) begin
				pos_q[e]   <= nx_pos[e];
				skip_q[e]  <= nx_skip[e];
				fail_q[e]  <= nx_fail[e];
				match_q[e] <= nx_match[e];
				act_q[e]   <= nx_act[e];
			end else if (cmd.finish) begin
				pos_q[e]   <= '0;
				skip_q[e]  <= 1'b0;
				fail_q[e]  <= 1'b0;
				match_q[e] <= 1'b0;
				act_q[e]   <= 1'b0;
			end else if (cmd.commit && ld_busy_q && ld_slot_q == SW'(e)) begin
				used_q[e]  <= 1'b1;
				pos_q[e]   <= '0;
				skip_q[e]  <= 1'b0;
				fail_q[e]  <= (tcnt_q != '0);
				match_q[e] <= 1'b0;
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.commit && ld_busy_q && ld_slot_q == SW'(e)) begin
				len_q[e] <= ld_cnt_q;
			end
		end
	end

	for (genvar i = 0; i < MASK_W; i++) begin : g_mask
		if (i < ENTRIES) begin : g_on
			assign fin_mask[i] = fin[i];
		end else begin : g_off
			assign fin_mask[i] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcnt_q    <= '0;
			ld_busy_q <= 1'b0;
			ld_rej_q  <= 1'b0;
			ld_slot_q <= '0;
			ld_cnt_q  <= '0;
		end else begin
			if (cmd.topic_byte) begin
				tcnt_q <= tcnt_q + TW'(1);
			end else if (cmd.finish) begin
				tcnt_q <= '0;
			end
			if (cmd.load_byte) begin
				ld_busy_q <= ld_busy_n;
				ld_rej_q  <= ld_rej_n;
				ld_slot_q <= ld_slot_n;
				ld_cnt_q  <= wr_en ? ld_cnt_cur + FW'(1) : ld_cnt_cur;
			end else if (cmd.commit) begin
				ld_busy_q <= 1'b0;
				ld_rej_q  <= 1'b0;
				ld_slot_q <= '0;
				ld_cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.topic_byte) begin
			ch_q <= data_byte;
		end
		if (cmd.finish) begin
			kind_q <= KIND_MATCH;
			mask_q <= fin_mask;
			slot_q <= '0;
		end else if (cmd.commit) begin
			kind_q <= ld_busy_q ? KIND_STORED : KIND_FULL;
			mask_q <= '0;
			slot_q <= ld_busy_q ? SLOT_OUT_W'(ld_slot_q) : '0;
		end
	end

	assign stat.topic_sat = (tcnt_q == TW'(TOPIC_CHARS - 1));
	assign stat.cont      = |nx_act;
	assign stat.act_any   = |act_q;
	assign res_kind = kind_q;
	assign res_mask = mask_q;
	assign res_slot = slot_q;
endmodule
`default_nettype wire

// File: src/tfm_ctrl.sv
// Controller: sequences each transfer through the datapath and owns the handshakes.
`default_nettype none
module tfm_ctrl import tfm_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_type,
	input  wire logic      in_last,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire tfm_stat_t stat,
	output tfm_cmd_t       cmd
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_EVAL, ST_WAIT, ST_FWAIT, ST_FIN, ST_LRES
	} state_t;

	state_t state_q;
	logic   last_q, out_valid_q, fire, out_free;

	assign fire     = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd.load_byte  = fire && in_type == REQ_FILTER;
		cmd.topic_byte = fire && in_type == REQ_TOPIC && !stat.topic_sat;
		cmd.step       = (state_q == ST_EVAL);
		cmd.finish     = (state_q == ST_FIN) && out_free;
		cmd.commit     = (state_q == ST_LRES) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (fire) begin
						last_q <= in_last;
						if (in_type == REQ_FILTER) begin
							state_q <= in_last ? ST_LRES : ST_IDLE;
						end else if (!stat.topic_sat) begin
							state_q <= ST_EVAL;
						end else begin
							state_q <= in_last ? ST_FIN : ST_IDLE;
						end
					end
				end
				ST_EVAL: begin
					if (stat.cont) begin
						state_q <= ST_WAIT;
					end else begin
						state_q <= last_q ? ST_FWAIT : ST_IDLE;
					end
				end
				ST_WAIT:  state_q <= ST_EVAL;
				ST_FWAIT: state_q <= ST_FIN;
				ST_FIN, ST_LRES: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

// File: src/topic_filter_match_table.sv
// Top level of the topic filter match table.
//
//  channel | dir | tdata                          | tuser         | tlast
//  s_      | in  | data_byte[7:0]                 | req_type      | last_byte
//  m_      | out | match_mask[11:0], slot[15:12]  | result_kind   | -
//
// A filter byte is accepted in ST_IDLE; the last one also passes ST_LRES to report.
// A topic byte passes ST_EVAL (skipped once the topic is past its length cap), plus
// ST_WAIT and ST_EVAL again per round while some entry reaches a '+' on a '/', as
// the read of every entry's filter memory is registered. The last topic transfer
// adds ST_FWAIT and ST_FIN for the final read and mask (only ST_FIN past the cap).
// Reset is asynchronous; no clearing pass is needed.
// A result holds in the output register until m_tready; the next result then
// waits in the controller, which stops intake until the first one leaves.
`default_nettype none
module topic_filter_match_table import tfm_pkg::*; #(
	parameter int ENTRIES      = ENTRIES_DEF,
	parameter int FILTER_CHARS = FILTER_CHARS_DEF,
	parameter int TOPIC_CHARS  = TOPIC_CHARS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // data_byte
	input  wire logic        s_tuser,   // req_type
	input  wire logic        s_tlast,   // last_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata,   // match_mask[11:0], slot_index[15:12]
	output logic      [1:0]  m_tuser    // result_kind
);
	tfm_cmd_t              cmd;
	tfm_stat_t             stat;
	logic [MASK_W-1:0]     res_mask;
	logic [SLOT_OUT_W-1:0] res_slot;

	tfm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_type  (s_tuser),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tfm_datapath #(
		.ENTRIES     (ENTRIES),
		.FILTER_CHARS(FILTER_CHARS),
		.TOPIC_CHARS (TOPIC_CHARS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.data_byte(s_tdata),
		.stat     (stat),
		.res_kind (m_tuser),
		.res_mask (res_mask),
		.res_slot (res_slot)
	);

	assign m_tdata = {res_slot, res_mask};

`include "topic_filter_match_table_assert.svh"

	`TFM_ASSERT_NOW(a_idle_no_matcher, s_tready, !stat.act_any, "matcher active while idle")
	`TFM_ASSERT_NEXT(a_filter_last_holds,
		s_tvalid && s_tready && s_tuser == REQ_FILTER && s_tlast, !s_tready,
		"filter end not reported")
	`TFM_ASSERT_NOW(a_load_mask_zero, m_tvalid && m_tuser != KIND_MATCH, res_mask == '0,
		"mask set on load result")
endmodule
`default_nettype wire
